// ===== rtl/core/sps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SPS colour extractor package
// Holds the syntax phases, the bit reader modes and the shared helpers.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int GolombWidth = 32;
	localparam int ZcW = 6;

	typedef enum logic [5:0] {
		PH_PROFILE, PH_SKIP16, PH_SPSID, PH_CHROMA, PH_SEPPLANE, PH_DEPTHL,
		PH_DEPTHC, PH_LOSSLESS, PH_SMPRESENT, PH_LISTFLAG, PH_DELTA, PH_LOG2FN,
		PH_POCTYPE, PH_LOG2POC, PH_DELTAZERO, PH_OFFNONREF, PH_OFFTB,
		PH_NUMCYCLE, PH_OFFREF, PH_NUMREF, PH_GAPS, PH_WIDTH, PH_HEIGHT,
		PH_FRAMEMBS, PH_MBAFF, PH_DIRECT8, PH_CROPFLAG, PH_CROP, PH_VUIFLAG,
		PH_ARFLAG, PH_ARIDC, PH_SAR, PH_OVERFLAG, PH_OVERAPP, PH_VSTFLAG,
		PH_VFORMAT, PH_FULLRANGE, PH_CDFLAG, PH_PRIM, PH_TRANS, PH_MATRIX,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {RD_FIXED, RD_PREFIX, RD_SUFFIX} rd_mode_t;

	typedef enum logic [1:0] {SQ_IDLE, SQ_SHIFT, SQ_OUT} seq_state_t;

	typedef struct packed {
		logic bit_valid;
		logic bit_val;
		logic clear;
	} bit_ctl_t;

	typedef struct packed {
		logic       found;
		logic       full_range;
		logic       seen;
		logic [7:0] prim;
		logic [7:0] trans;
		logic [7:0] matrix;
	} result_t;

	function automatic logic high_profile(input logic [7:0] p);
		return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
			p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 || p == 8'd128;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sps_bit_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SPS bit walker
// Consumes one bit per cycle in which bit_valid is set and walks the SPS syntax up to the colour codes.
// ----------------------------------------------------------------------------
module sps_bit_walker (
	input  wire              clk,
	input  wire              arst_n,
	input  sps_pkg::bit_ctl_t ctl,
	output sps_pkg::result_t  res
);
	import sps_pkg::*;

	phase_t                  phase_q, ph_d;
	rd_mode_t                mode_q, mode_d;
	logic [ZcW-1:0]          zc_q, zc_d;
	logic [GolombWidth-1:0]  val_q, val_d;
	logic [ZcW-1:0]          left_q, left_d;
	logic [7:0]              prof_q, prof_d;
	logic                    c444_q, c444_d;
	logic [3:0]              lidx_q, lidx_d;
	logic [6:0]              lcnt_q, lcnt_d;
	logic [7:0]              nscale_q, nscale_d;
	logic [7:0]              lscale_q, lscale_d;
	logic [GolombWidth-1:0]  loop_q, loop_d;
	result_t                 res_q, res_d;

	logic                    fdone;
	logic [GolombWidth-1:0]  fv;
	logic [GolombWidth-1:0]  shifted;
	logic [ZcW-1:0]          left_dec;
	logic [GolombWidth-1:0]  cmag;
	logic [8:0]              delta;
	logic [7:0]              ns;
	logic [3:0]              lidx_inc;

	assign shifted  = {val_q[GolombWidth-2:0], ctl.bit_val};
	assign left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

	always_comb begin
		fdone = 1'b0;
		fv    = shifted;
		if (ctl.bit_valid && phase_q != PH_DONE) begin
			unique case (mode_q)
				RD_FIXED: fdone = (left_dec == '0);
				RD_PREFIX: begin
					fdone = ctl.bit_val && (zc_q == '0);
					fv    = '0;
				end
				default: begin
					fdone = (left_dec == '0);
					fv    = shifted + ((GolombWidth'(1) << zc_q[4:0]) - 1'b1);
				end
			endcase
		end
	end

	always_comb begin
		cmag = fv >> 1;
		if (fv[0]) begin
			delta = (cmag >= 32'd127) ? 9'sd127 : 9'(cmag + 1'b1);
		end else begin
			delta = (cmag > 32'd128) ? 9'h180 : 9'(-cmag);
		end
		ns = 8'(lscale_q + delta[7:0]);
	end

	assign lidx_inc = lidx_q + 1'b1;

	always_comb begin
		ph_d = phase_q; mode_d = mode_q; zc_d = zc_q; val_d = val_q;
		left_d = left_q; prof_d = prof_q; c444_d = c444_q; lidx_d = lidx_q;
		lcnt_d = lcnt_q; nscale_d = nscale_q; lscale_d = lscale_q;
		loop_d = loop_q; res_d = res_q;
		if (ctl.clear) begin
			ph_d = PH_PROFILE; mode_d = RD_FIXED; zc_d = '0; val_d = '0;
			left_d = ZcW'(8); prof_d = '0; c444_d = 1'b0; lidx_d = '0;
			lcnt_d = '0; nscale_d = 8'd8; lscale_d = 8'd8; loop_d = '0;
			res_d = '0;
		end else if (ctl.bit_valid && phase_q != PH_DONE) begin
			unique case (mode_q)
				RD_FIXED: begin
					val_d = shifted; left_d = left_dec;
				end
				RD_PREFIX: begin
					if (!ctl.bit_val) begin
						zc_d = zc_q + 1'b1;
						if (zc_q == ZcW'(GolombWidth - 1)) ph_d = PH_DONE;
					end else if (zc_q != '0) begin
						mode_d = RD_SUFFIX; left_d = zc_q; val_d = '0;
					end
				end
				default: begin
					val_d = shifted; left_d = left_dec;
				end
			endcase
			if (fdone) begin
				mode_d = RD_PREFIX; zc_d = '0; val_d = '0;
				unique case (phase_q)
					PH_PROFILE: begin
						prof_d = fv[7:0]; ph_d = PH_SKIP16;
						mode_d = RD_FIXED; left_d = ZcW'(16);
					end
					PH_SKIP16: ph_d = PH_SPSID;
					PH_SPSID: ph_d = high_profile(prof_q) ? PH_CHROMA : PH_LOG2FN;
					PH_CHROMA: begin
						c444_d = (fv == 32'd3);
						if (fv == 32'd3) begin
							ph_d = PH_SEPPLANE; mode_d = RD_FIXED; left_d = ZcW'(1);
							zc_d = zc_q;
						end else ph_d = PH_DEPTHL;
					end
					PH_SEPPLANE: ph_d = PH_DEPTHL;
					PH_DEPTHL: ph_d = PH_DEPTHC;
					PH_DEPTHC: begin
						ph_d = PH_LOSSLESS; mode_d = RD_FIXED; left_d = ZcW'(1);
						zc_d = zc_q;
					end
					PH_LOSSLESS: begin
						ph_d = PH_SMPRESENT; mode_d = RD_FIXED; left_d = ZcW'(1);
						zc_d = zc_q;
					end
					PH_SMPRESENT: begin
						if (fv[0]) begin
							lidx_d = '0; ph_d = PH_LISTFLAG; mode_d = RD_FIXED;
							left_d = ZcW'(1); zc_d = zc_q;
						end else ph_d = PH_LOG2FN;
					end
					PH_LISTFLAG: begin
						if (fv[0]) begin
							nscale_d = 8'd8; lscale_d = 8'd8;
							lcnt_d = (lidx_q < 4'd6) ? 7'd16 : 7'd64;
							ph_d = PH_DELTA;
						end else begin
							lidx_d = lidx_inc;
							if (lidx_inc < (c444_q ? 4'd12 : 4'd8)) begin
								ph_d = PH_LISTFLAG; mode_d = RD_FIXED;
								left_d = ZcW'(1); zc_d = zc_q;
							end else ph_d = PH_LOG2FN;
						end
					end
					PH_DELTA: begin
						nscale_d = ns;
						if (ns != 8'd0) lscale_d = ns;
						lcnt_d = lcnt_q - 1'b1;
						if (lcnt_q == 7'd1 || ns == 8'd0) begin
							lidx_d = lidx_inc;
							if (lidx_inc < (c444_q ? 4'd12 : 4'd8)) begin
								ph_d = PH_LISTFLAG; mode_d = RD_FIXED;
								left_d = ZcW'(1); zc_d = zc_q;
							end else ph_d = PH_LOG2FN;
						end else ph_d = PH_DELTA;
					end
					PH_LOG2FN: ph_d = PH_POCTYPE;
					PH_POCTYPE: begin
						if (fv == '0) ph_d = PH_LOG2POC;
						else if (fv == 32'd1) begin
							ph_d = PH_DELTAZERO; mode_d = RD_FIXED;
							left_d = ZcW'(1); zc_d = zc_q;
						end else ph_d = PH_NUMREF;
					end
					PH_LOG2POC: ph_d = PH_NUMREF;
					PH_DELTAZERO: ph_d = PH_OFFNONREF;
					PH_OFFNONREF: ph_d = PH_OFFTB;
					PH_OFFTB: ph_d = PH_NUMCYCLE;
					PH_NUMCYCLE: begin
						loop_d = fv;
						ph_d = (fv == '0) ? PH_NUMREF : PH_OFFREF;
					end
					PH_OFFREF: begin
						loop_d = loop_q - 1'b1;
						ph_d = (loop_q == 32'd1) ? PH_NUMREF : PH_OFFREF;
					end
					PH_NUMREF: begin
						ph_d = PH_GAPS; mode_d = RD_FIXED; left_d = ZcW'(1); zc_d = zc_q;
					end
					PH_GAPS: ph_d = PH_WIDTH;
					PH_WIDTH: ph_d = PH_HEIGHT;
					PH_HEIGHT: begin
						ph_d = PH_FRAMEMBS; mode_d = RD_FIXED; left_d = ZcW'(1);
						zc_d = zc_q;
					end
					PH_FRAMEMBS, PH_MBAFF, PH_DIRECT8, PH_ARFLAG, PH_OVERFLAG,
					PH_OVERAPP, PH_SAR, PH_ARIDC, PH_VFORMAT, PH_FULLRANGE,
					PH_PRIM, PH_TRANS: begin
						mode_d = RD_FIXED; zc_d = zc_q; left_d = ZcW'(1);
						priority case (phase_q)
							PH_FRAMEMBS: ph_d = fv[0] ? PH_DIRECT8 : PH_MBAFF;
							PH_MBAFF: ph_d = PH_DIRECT8;
							PH_DIRECT8: ph_d = PH_CROPFLAG;
							PH_ARFLAG: begin
								ph_d = fv[0] ? PH_ARIDC : PH_OVERFLAG;
								if (fv[0]) left_d = ZcW'(8);
							end
							PH_ARIDC: begin
								ph_d = (fv == 32'd255) ? PH_SAR : PH_OVERFLAG;
								if (fv == 32'd255) left_d = ZcW'(32);
							end
							PH_SAR: ph_d = PH_OVERFLAG;
							PH_OVERFLAG: ph_d = fv[0] ? PH_OVERAPP : PH_VSTFLAG;
							PH_OVERAPP: ph_d = PH_VSTFLAG;
							PH_VFORMAT: ph_d = PH_FULLRANGE;
							PH_FULLRANGE: begin
								res_d.full_range = fv[0]; res_d.seen = 1'b1;
								ph_d = PH_CDFLAG;
							end
							PH_PRIM: begin
								res_d.prim = fv[7:0]; ph_d = PH_TRANS; left_d = ZcW'(8);
							end
							default: begin
								res_d.trans = fv[7:0]; ph_d = PH_MATRIX; left_d = ZcW'(8);
							end
						endcase
					end
					PH_CROPFLAG: begin
						if (fv[0]) begin
							loop_d = 32'd4; ph_d = PH_CROP;
						end else begin
							ph_d = PH_VUIFLAG; mode_d = RD_FIXED; left_d = ZcW'(1);
							zc_d = zc_q;
						end
					end
					PH_CROP: begin
						loop_d = loop_q - 1'b1;
						if (loop_q == 32'd1) begin
							ph_d = PH_VUIFLAG; mode_d = RD_FIXED; left_d = ZcW'(1);
							zc_d = zc_q;
						end else ph_d = PH_CROP;
					end
					PH_VUIFLAG, PH_VSTFLAG, PH_CDFLAG: begin
						mode_d = RD_FIXED; zc_d = zc_q;
						if (!fv[0]) ph_d = PH_DONE;
						else begin
							priority case (phase_q)
								PH_VUIFLAG: begin ph_d = PH_ARFLAG; left_d = ZcW'(1); end
								PH_VSTFLAG: begin ph_d = PH_VFORMAT; left_d = ZcW'(3); end
								default: begin ph_d = PH_PRIM; left_d = ZcW'(8); end
							endcase
						end
					end
					PH_MATRIX: begin
						res_d.matrix = fv[7:0]; res_d.found = 1'b1;
						ph_d = PH_DONE; mode_d = mode_q; zc_d = zc_q; val_d = shifted;
					end
					default: begin
						ph_d = PH_DONE; mode_d = mode_q; zc_d = zc_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PROFILE; mode_q <= RD_FIXED; zc_q <= '0; val_q <= '0;
			left_q <= ZcW'(8); prof_q <= '0; c444_q <= 1'b0; lidx_q <= '0;
			lcnt_q <= '0; nscale_q <= 8'd8; lscale_q <= 8'd8; loop_q <= '0;
			res_q <= '0;
		end else begin
			phase_q <= ph_d; mode_q <= mode_d; zc_q <= zc_d; val_q <= val_d;
			left_q <= left_d; prof_q <= prof_d; c444_q <= c444_d; lidx_q <= lidx_d;
			lcnt_q <= lcnt_d; nscale_q <= nscale_d; lscale_q <= lscale_d;
			loop_q <= loop_d; res_q <= res_d;
		end
	end

	always_comb begin
		res            = '0;
		res.found      = res_q.found;
		res.seen       = res_q.seen;
		res.full_range = res_q.seen & res_q.full_range;
		if (res_q.found) begin
			res.prim   = res_q.prim;
			res.trans  = res_q.trans;
			res.matrix = res_q.matrix;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sps_colour_info_extractor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SPS colour information extractor
// Parses one H.264 SPS and returns the VUI colour description.
// ----------------------------------------------------------------------------
// Each input transaction is taken in an accepting cycle, after which the
// bits of the byte are fed one by one, most significant bit first, to the
// bit walker. After a byte marked last the result is presented from the
// next cycle and held until taken, and the next transaction is accepted in
// the cycle after the result is taken at the earliest. The block is stalled
// while it shifts a byte or holds an untaken result.
module sps_colour_info_extractor (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] data_byte,
	input  wire        last_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       found,
	output logic       full_range,
	output logic       full_range_seen,
	output logic [7:0] prim_code,
	output logic [7:0] transfer_code,
	output logic [7:0] matrix_code
);
	import sps_pkg::*;

	seq_state_t st_q, st_d;
	logic [7:0] byte_q;
	logic       last_q;
	logic [2:0] cnt_q;
	bit_ctl_t   ctl;
	result_t    res;
	logic       acc;

	assign acc = in_valid && !in_stall;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			SQ_IDLE: if (acc) st_d = SQ_SHIFT;
			SQ_SHIFT: if (cnt_q == 3'd7) st_d = last_q ? SQ_OUT : SQ_IDLE;
			default: if (!out_stall) st_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (st_q != SQ_IDLE);
		out_valid     = (st_q == SQ_OUT);
		ctl.bit_valid = (st_q == SQ_SHIFT);
		ctl.bit_val   = byte_q[7];
		ctl.clear     = (st_q == SQ_OUT) && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= SQ_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == SQ_SHIFT) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			byte_q <= data_byte;
			last_q <= last_byte;
		end else if (st_q == SQ_SHIFT) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end
	end

	sps_bit_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.res    (res)
	);

	assign found           = res.found;
	assign full_range      = res.full_range;
	assign full_range_seen = res.seen;
	assign prim_code       = res.prim;
	assign transfer_code   = res.trans;
	assign matrix_code     = res.matrix;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(prim_code))
		else $error("Result changed while stalled.");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("Input taken while result pending.");
	a_found_codes: assert property (@(posedge clk) disable iff (!arst_n)
		!found |-> prim_code == 8'd0 && matrix_code == 8'd0)
		else $error("Codes nonzero without colour description.");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// SPS colour information extractor testbench
// Streams SPS byte sequences, well formed, truncated and random, into the
// block and compares every colour result with a bit-level parser model.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sps_pkg::*;

	typedef struct packed {
		logic       found;
		logic       full_range;
		logic       seen;
		logic [7:0] prim;
		logic [7:0] trans;
		logic [7:0] matrix;
	} colour_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_stall;
	logic       found;
	logic       full_range;
	logic       full_range_seen;
	logic [7:0] prim_code;
	logic [7:0] transfer_code;
	logic [7:0] matrix_code;

	sps_colour_info_extractor i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last_byte(last_byte), .out_valid(out_valid),
		.out_stall(out_stall), .found(found), .full_range(full_range),
		.full_range_seen(full_range_seen), .prim_code(prim_code),
		.transfer_code(transfer_code),
		.matrix_code(matrix_code)
	);

	colour_t    colour_queue[$];
	int         fail_count = 0;
	int         items_sent = 0;
	bit         quiet_tail = 0;

	// Parser state.
	phase_t     ph;
	rd_mode_t   rmode;
	int unsigned zeros;
	logic [31:0] gval;
	int unsigned bits_left;
	logic [7:0] prof;
	bit         is444;
	int unsigned lidx;
	int unsigned lcount;
	logic [7:0] nscale;
	logic [7:0] lscale;
	logic [31:0] loops;
	colour_t    acc;

	// Bit string under construction.
	bit         bitbuf[$];

	function automatic bit is_high(input logic [7:0] p);
		return p == 100 || p == 110 || p == 122 || p == 244 || p == 44 ||
			p == 83 || p == 86 || p == 118 || p == 128;
	endfunction

	task automatic fixed_field(input phase_t p, input int unsigned n);
		ph = p; rmode = RD_FIXED; bits_left = n; gval = 0;
	endtask

	task automatic ue_field(input phase_t p);
		ph = p; rmode = RD_PREFIX; zeros = 0; gval = 0;
	endtask

	task automatic parser_reset();
		fixed_field(PH_PROFILE, 8);
		zeros = 0; prof = 0; is444 = 0; lidx = 0; lcount = 0;
		nscale = 8; lscale = 8; loops = 0; acc = '0;
	endtask

	task automatic next_list();
		lidx++;
		if (lidx < (is444 ? 12 : 8)) fixed_field(PH_LISTFLAG, 1);
		else ue_field(PH_LOG2FN);
	endtask

	task automatic field_complete(input logic [31:0] v);
		int d;
		logic [31:0] mag;
		case (ph)
			PH_PROFILE: begin prof = v[7:0]; fixed_field(PH_SKIP16, 16); end
			PH_SKIP16: ue_field(PH_SPSID);
			PH_SPSID: if (is_high(prof)) ue_field(PH_CHROMA); else ue_field(PH_LOG2FN);
			PH_CHROMA: begin
				is444 = (v == 3);
				if (is444) fixed_field(PH_SEPPLANE, 1); else ue_field(PH_DEPTHL);
			end
			PH_SEPPLANE: ue_field(PH_DEPTHL);
			PH_DEPTHL: ue_field(PH_DEPTHC);
			PH_DEPTHC: fixed_field(PH_LOSSLESS, 1);
			PH_LOSSLESS: fixed_field(PH_SMPRESENT, 1);
			PH_SMPRESENT: begin
				if (v != 0) begin lidx = 0; fixed_field(PH_LISTFLAG, 1); end
				else ue_field(PH_LOG2FN);
			end
			PH_LISTFLAG: begin
				if (v != 0) begin
					nscale = 8; lscale = 8;
					lcount = lidx < 6 ? 16 : 64;
					ue_field(PH_DELTA);
				end else next_list();
			end
			PH_DELTA: begin
				if (v[0]) begin
					mag = (v >> 1) + 1;
					d = mag > 127 ? 127 : int'(mag);
				end else begin
					mag = v >> 1;
					d = mag > 128 ? -128 : -int'(mag);
				end
				nscale = 8'(int'(lscale) + d + 256);
				if (nscale != 0) lscale = nscale;
				lcount--;
				if (lcount == 0 || nscale == 0) next_list(); else ue_field(PH_DELTA);
			end
			PH_LOG2FN: ue_field(PH_POCTYPE);
			PH_POCTYPE: begin
				if (v == 0) ue_field(PH_LOG2POC);
				else if (v == 1) fixed_field(PH_DELTAZERO, 1);
				else ue_field(PH_NUMREF);
			end
			PH_LOG2POC: ue_field(PH_NUMREF);
			PH_DELTAZERO: ue_field(PH_OFFNONREF);
			PH_OFFNONREF: ue_field(PH_OFFTB);
			PH_OFFTB: ue_field(PH_NUMCYCLE);
			PH_NUMCYCLE: begin
				loops = v;
				if (v == 0) ue_field(PH_NUMREF); else ue_field(PH_OFFREF);
			end
			PH_OFFREF: begin
				loops--;
				if (loops == 0) ue_field(PH_NUMREF); else ue_field(PH_OFFREF);
			end
			PH_NUMREF: fixed_field(PH_GAPS, 1);
			PH_GAPS: ue_field(PH_WIDTH);
			PH_WIDTH: ue_field(PH_HEIGHT);
			PH_HEIGHT: fixed_field(PH_FRAMEMBS, 1);
			PH_FRAMEMBS: if (v == 0) fixed_field(PH_MBAFF, 1); else fixed_field(PH_DIRECT8, 1);
			PH_MBAFF: fixed_field(PH_DIRECT8, 1);
			PH_DIRECT8: fixed_field(PH_CROPFLAG, 1);
			PH_CROPFLAG: begin
				if (v != 0) begin loops = 4; ue_field(PH_CROP); end
				else fixed_field(PH_VUIFLAG, 1);
			end
			PH_CROP: begin
				loops--;
				if (loops == 0) fixed_field(PH_VUIFLAG, 1); else ue_field(PH_CROP);
			end
			PH_VUIFLAG: if (v != 0) fixed_field(PH_ARFLAG, 1); else ph = PH_DONE;
			PH_ARFLAG: if (v != 0) fixed_field(PH_ARIDC, 8); else fixed_field(PH_OVERFLAG, 1);
			PH_ARIDC: if (v == 255) fixed_field(PH_SAR, 32); else fixed_field(PH_OVERFLAG, 1);
			PH_SAR: fixed_field(PH_OVERFLAG, 1);
			PH_OVERFLAG: if (v != 0) fixed_field(PH_OVERAPP, 1); else fixed_field(PH_VSTFLAG, 1);
			PH_OVERAPP: fixed_field(PH_VSTFLAG, 1);
			PH_VSTFLAG: if (v != 0) fixed_field(PH_VFORMAT, 3); else ph = PH_DONE;
			PH_VFORMAT: fixed_field(PH_FULLRANGE, 1);
			PH_FULLRANGE: begin
				acc.full_range = v[0]; acc.seen = 1;
				fixed_field(PH_CDFLAG, 1);
			end
			PH_CDFLAG: if (v != 0) fixed_field(PH_PRIM, 8); else ph = PH_DONE;
			PH_PRIM: begin acc.prim = v[7:0]; fixed_field(PH_TRANS, 8); end
			PH_TRANS: begin acc.trans = v[7:0]; fixed_field(PH_MATRIX, 8); end
			PH_MATRIX: begin acc.matrix = v[7:0]; acc.found = 1; ph = PH_DONE; end
			default: ph = PH_DONE;
		endcase
	endtask

	task automatic parse_bit(input bit b);
		if (ph == PH_DONE) return;
		if (rmode == RD_FIXED) begin
			gval = {gval[30:0], b};
			if (bits_left > 0) bits_left--;
			if (bits_left == 0) field_complete(gval);
		end else if (rmode == RD_PREFIX) begin
			if (!b) begin
				zeros++;
				if (zeros > GolombWidth - 1) ph = PH_DONE;
			end else if (zeros == 0) field_complete(0);
			else begin
				rmode = RD_SUFFIX; bits_left = zeros; gval = 0;
			end
		end else begin
			gval = {gval[30:0], b};
			if (bits_left > 0) bits_left--;
			if (bits_left == 0) field_complete(gval + ((32'd1 << zeros[4:0]) - 1));
		end
	endtask

	task automatic predict_byte(input logic [7:0] db, input bit lb);
		colour_t r;
		for (int i = 7; i >= 0; i--) parse_bit(db[i]);
		if (lb) begin
			r.found = acc.found;
			r.seen = acc.seen;
			r.full_range = acc.seen ? acc.full_range : 1'b0;
			r.prim = acc.found ? acc.prim : 8'd0;
			r.trans = acc.found ? acc.trans : 8'd0;
			r.matrix = acc.found ? acc.matrix : 8'd0;
			colour_queue.push_back(r);
			parser_reset();
		end
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_byte(input logic [7:0] db, input bit lb);
		int gap;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1; data_byte <= db; last_byte <= lb;
		predict_byte(db, lb);
		items_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	// Bit string builders.
	task automatic put_bits(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--) bitbuf.push_back(v[i]);
	endtask

	task automatic put_ue(input logic [31:0] v);
		logic [32:0] x;
		int n;
		x = {1'b0, v} + 1;
		n = 0;
		for (int i = 32; i >= 0; i--) if (x[i] && n == 0) n = i + 1;
		put_bits(0, n - 1);
		for (int i = n - 1; i >= 0; i--) bitbuf.push_back(x[i]);
	endtask

	task automatic flush_nal(input int cut);
		int nbytes;
		logic [7:0] b;
		while (bitbuf.size() % 8 != 0) bitbuf.push_back(1'($urandom));
		nbytes = bitbuf.size() / 8;
		if (cut > 0 && cut < nbytes) nbytes = cut;
		for (int k = 0; k < nbytes; k++) begin
			for (int i = 0; i < 8; i++) b[7 - i] = bitbuf[k * 8 + i];
			send_byte(b, k == nbytes - 1);
		end
		bitbuf.delete();
	endtask

	function automatic logic [31:0] rnd_ue();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(0, 40);
			2: return $urandom_range(0, 2000);
			default: return $urandom;
		endcase
	endfunction

	task automatic build_sps(input logic [7:0] p, input int chroma, input bit lists,
			input int poc, input bit vui, input bit full_cd);
		logic [7:0] high_list[9];
		int cnt;
		high_list = '{100, 110, 122, 244, 44, 83, 86, 118, 128};
		put_bits(p, 8);
		put_bits($urandom, 16);
		put_ue($urandom_range(0, 31));
		if (is_high(p)) begin
			put_ue(chroma);
			if (chroma == 3) put_bits($urandom, 1);
			put_ue($urandom_range(0, 6));
			put_ue($urandom_range(0, 6));
			put_bits($urandom, 1);
			put_bits(lists, 1);
			if (lists) begin
				for (int l = 0; l < (chroma == 3 ? 12 : 8); l++) begin
					if ($urandom_range(0, 2) == 0) begin
						put_bits(0, 1);
						continue;
					end
					put_bits(1, 1);
					cnt = l < 6 ? 16 : 64;
					for (int e = 0; e < cnt; e++) begin
						if ($urandom_range(0, 20) == 0) begin
							put_ue(300 + $urandom_range(0, 600));
							if ($urandom_range(0, 1)) break;
						end else put_ue($urandom_range(0, 6));
						if ($urandom_range(0, 40) == 0) break;
					end
				end
			end
		end
		put_ue($urandom_range(0, 12));
		put_ue(poc);
		if (poc == 0) put_ue($urandom_range(0, 12));
		else if (poc == 1) begin
			put_bits($urandom, 1);
			put_ue(rnd_ue()); put_ue(rnd_ue());
			cnt = $urandom_range(0, 5);
			put_ue(cnt);
			for (int i = 0; i < cnt; i++) put_ue(rnd_ue());
		end
		put_ue($urandom_range(0, 16));
		put_bits($urandom, 1);
		put_ue(rnd_ue()); put_ue(rnd_ue());
		put_bits($urandom, 3);
		if (bitbuf[$ - 2] == 1'b1) void'(bitbuf.pop_back());
		if ($urandom_range(0, 1)) begin
			put_bits(1, 1);
			for (int i = 0; i < 4; i++) put_ue(rnd_ue());
		end else put_bits(0, 1);
		put_bits(vui, 1);
		if (!vui) return;
		if ($urandom_range(0, 1)) begin
			put_bits(1, 1);
			if ($urandom_range(0, 1)) begin put_bits(255, 8); put_bits($urandom, 32); end
			else put_bits($urandom_range(0, 254), 8);
		end else put_bits(0, 1);
		if ($urandom_range(0, 1)) begin put_bits(1, 1); put_bits($urandom, 1); end
		else put_bits(0, 1);
		if (!full_cd && $urandom_range(0, 2) == 0) begin put_bits(0, 1); return; end
		put_bits(1, 1);
		put_bits($urandom, 3);
		put_bits($urandom, 1);
		if (!full_cd && $urandom_range(0, 2) == 0) begin put_bits(0, 1); return; end
		put_bits(1, 1);
		put_bits($urandom, 24);
		if (high_list[0] == 0) put_bits(0, 1);
	endtask

	function automatic logic [7:0] rnd_profile();
		logic [7:0] hl[9];
		hl = '{100, 110, 122, 244, 44, 83, 86, 118, 128};
		if ($urandom_range(0, 2) == 0) return 8'($urandom);
		if ($urandom_range(0, 1)) return hl[$urandom_range(0, 8)];
		return 66;
	endfunction

	task automatic random_sps(input int cut);
		build_sps(rnd_profile(), $urandom_range(0, 3), $urandom_range(0, 3) == 0,
			$urandom_range(0, 2), $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)));
		put_bits($urandom, $urandom_range(0, 20));
		flush_nal(cut);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (colour_queue.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		build_sps(66, 1, 0, 0, 1, 1);
		flush_nal(0);
		build_sps(100, 3, 1, 1, 1, 1);
		flush_nal(0);
		build_sps(244, 1, 1, 2, 1, 1);
		flush_nal(0);
		build_sps(77, 0, 0, 2, 0, 1);
		flush_nal(0);
		send_byte(8'h00, 0);
		send_byte(8'h00, 0);
		send_byte(8'h00, 0);
		send_byte(8'h00, 0);
		send_byte(8'h00, 0);
		send_byte(8'hFF, 1);
		send_byte(8'hFF, 1);
		send_byte(8'h00, 1);
	endtask

	task automatic test_pause();
		random_sps(0);
		wait_drained();
		random_sps(0);
	endtask

	task automatic test_random();
		while (items_sent < 1550) begin
			if ($urandom_range(0, 9) == 0) begin
				send_byte(8'($urandom), $urandom_range(0, 3) == 0);
			end else begin
				random_sps($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0);
			end
			if (items_sent > 1400) quiet_tail = 1;
		end
	endtask

	initial begin
		in_valid = 0; data_byte = 0; last_byte = 0; arst_n = 0;
		parser_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_pause();
		test_random();
		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	int stall_left = 0;
	initial out_stall = 0;
	always @(posedge clk) begin
		if (quiet_tail) out_stall <= 0;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= stall_left > 1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 16);
			out_stall <= 1;
		end else out_stall <= 0;
	end

	always @(posedge clk) begin
		colour_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (colour_queue.size() == 0) begin
				$error("result with none expected");
				fail_count++;
			end else begin
				e = colour_queue.pop_front();
				if (found !== e.found) begin
					$error("found exp %0d got %0d", e.found, found); fail_count++;
				end
				if (full_range !== e.full_range) begin
					$error("full_range exp %0d got %0d", e.full_range, full_range);
					fail_count++;
				end
				if (full_range_seen !== e.seen) begin
					$error("full_range_seen exp %0d got %0d", e.seen, full_range_seen);
					fail_count++;
				end
				if (prim_code !== e.prim) begin
					$error("prim_code exp %0d got %0d", e.prim, prim_code);
					fail_count++;
				end
				if (transfer_code !== e.trans) begin
					$error("transfer_code exp %0d got %0d", e.trans,
						transfer_code);
					fail_count++;
				end
				if (matrix_code !== e.matrix) begin
					$error("matrix_code exp %0d got %0d", e.matrix,
						matrix_code);
					fail_count++;
				end
			end
		end
	end
endmodule

// ===== files.f =====
rtl/core/sps_pkg.sv
rtl/core/sps_bit_walker.sv
rtl/core/sps_colour_info_extractor.sv
tb/sv/testbench.sv
